// ===== src/qrv_pkg.sv =====
// ----------------------------------------------------------------------------
// qrv_pkg
// Types and fixed sizes shared by the quaternion rotation datapath.
// ----------------------------------------------------------------------------
package qrv_pkg;

    localparam int DATA_WIDTH = 16;
    // Intermediate (q * v) terms carry three guard bits.
    localparam int MID_WIDTH  = DATA_WIDTH + 3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [MID_WIDTH-1:0]  mid_t;

    typedef struct packed {
        data_t quat_w;
        data_t quat_x;
        data_t quat_y;
        data_t quat_z;
        data_t vec_x;
        data_t vec_y;
        data_t vec_z;
    } qrv_request_t;

    typedef struct packed {
        data_t rot_x;
        data_t rot_y;
        data_t rot_z;
        logic  overflow;
    } qrv_result_t;

endpackage

// ===== src/qrv_mac4.sv =====
// ----------------------------------------------------------------------------
// qrv_mac4
// Two-stage signed sum of four products: registered multipliers, then
// add/subtract, round half up by FRAC_BITS and saturate to OUT_WIDTH.
// ----------------------------------------------------------------------------
module qrv_mac4 #(
    parameter int         A_WIDTH   = 16,
    parameter int         B_WIDTH   = 16,
    parameter int         OUT_WIDTH = 16,
    parameter int         FRAC_BITS = 14,
    parameter logic [3:0] SUB_MASK  = 4'b0000
) (
    input  logic                        clk,
    input  logic signed [A_WIDTH-1:0]   a [4],
    input  logic signed [B_WIDTH-1:0]   b [4],
    output logic signed [OUT_WIDTH-1:0] sum,
    output logic                        sat
);

    localparam int P_WIDTH   = A_WIDTH + B_WIDTH;
    localparam int SUM_WIDTH = P_WIDTH + 2;

    logic signed [P_WIDTH-1:0]   prod_reg [4];
    logic signed [SUM_WIDTH-1:0] acc;
    logic signed [SUM_WIDTH-1:0] shifted;
    logic [SUM_WIDTH-OUT_WIDTH:0] upper;
    logic signed [OUT_WIDTH-1:0] sum_reg;
    logic signed [OUT_WIDTH-1:0] sum_next;
    logic                        sat_reg;
    logic                        sat_next;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_reg[i] <= a[i] * b[i];
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (SUB_MASK[i])
            begin
                acc = acc - SUM_WIDTH'(prod_reg[i]);
            end
            else
            begin
                acc = acc + SUM_WIDTH'(prod_reg[i]);
            end
        end
        // add half an LSB, then floor shift
        shifted = (acc + (SUM_WIDTH'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        upper   = shifted[SUM_WIDTH-1:OUT_WIDTH-1];
        if ((&upper) || !(|upper))
        begin
            sum_next = shifted[OUT_WIDTH-1:0];
            sat_next = 1'b0;
        end
        else
        begin
            sum_next = shifted[SUM_WIDTH-1] ? {1'b1, {(OUT_WIDTH-1){1'b0}}}
                                            : {1'b0, {(OUT_WIDTH-1){1'b1}}};
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        sat_reg <= sat_next;
    end

    assign sum = sum_reg;
    assign sat = sat_reg;

endmodule

// ===== src/quaternion_rotate_vector.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a 3-vector by a quaternion: q * (0, v) * conj(q), fixed point.
// ----------------------------------------------------------------------------
// One request is taken in every cycle that start is high; busy stays low,
// since the four-stage pipeline never stalls. The result of each request
// shows on result with done high, in request order, after one multiplier
// stage and one round/saturate stage for the intermediate product, then
// the same two for the second product.
// The receiver must take each result in the cycle it is shown.
module quaternion_rotate_vector #(
    parameter int FRAC_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  qrv_pkg::qrv_request_t request,
    output logic                 done,
    output qrv_pkg::qrv_result_t  result
);

    import qrv_pkg::*;

    logic [3:0] vld_reg;
    logic [3:0] vld_next;

    data_t qw_d1_reg, qx_d1_reg, qy_d1_reg, qz_d1_reg;
    data_t qw_d2_reg, qx_d2_reg, qy_d2_reg, qz_d2_reg;

    mid_t  t_x, t_y, t_z, t_d;
    logic  sat_tx, sat_ty, sat_tz, sat_td;
    logic  ovf1_d1_reg, ovf1_d2_reg;

    data_t r_x, r_y, r_z;
    logic  sat_rx, sat_ry, sat_rz;

    assign vld_next = {vld_reg[2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // quaternion delayed to meet the intermediate terms
    always_ff @(posedge clk)
    begin
        qw_d1_reg   <= request.quat_w;
        qx_d1_reg   <= request.quat_x;
        qy_d1_reg   <= request.quat_y;
        qz_d1_reg   <= request.quat_z;
        qw_d2_reg   <= qw_d1_reg;
        qx_d2_reg   <= qx_d1_reg;
        qy_d2_reg   <= qy_d1_reg;
        qz_d2_reg   <= qz_d1_reg;
        ovf1_d1_reg <= sat_tx | sat_ty | sat_tz | sat_td;
        ovf1_d2_reg <= ovf1_d1_reg;
    end

    // first product: cross terms and dot term
    qrv_mac4 #(
        .A_WIDTH(DATA_WIDTH), .B_WIDTH(DATA_WIDTH), .OUT_WIDTH(MID_WIDTH),
        .FRAC_BITS(FRAC_BITS), .SUB_MASK(4'b0100)
    ) u_tx (
        .clk(clk),
        .a('{request.quat_w, request.quat_y, request.quat_z, data_t'(0)}),
        .b('{request.vec_x,  request.vec_z,  request.vec_y,  data_t'(0)}),
        .sum(t_x), .sat(sat_tx)
    );

    qrv_mac4 #(
        .A_WIDTH(DATA_WIDTH), .B_WIDTH(DATA_WIDTH), .OUT_WIDTH(MID_WIDTH),
        .FRAC_BITS(FRAC_BITS), .SUB_MASK(4'b0100)
    ) u_ty (
        .clk(clk),
        .a('{request.quat_w, request.quat_z, request.quat_x, data_t'(0)}),
        .b('{request.vec_y,  request.vec_x,  request.vec_z,  data_t'(0)}),
        .sum(t_y), .sat(sat_ty)
    );

    qrv_mac4 #(
        .A_WIDTH(DATA_WIDTH), .B_WIDTH(DATA_WIDTH), .OUT_WIDTH(MID_WIDTH),
        .FRAC_BITS(FRAC_BITS), .SUB_MASK(4'b0100)
    ) u_tz (
        .clk(clk),
        .a('{request.quat_w, request.quat_x, request.quat_y, data_t'(0)}),
        .b('{request.vec_z,  request.vec_y,  request.vec_x,  data_t'(0)}),
        .sum(t_z), .sat(sat_tz)
    );

    qrv_mac4 #(
        .A_WIDTH(DATA_WIDTH), .B_WIDTH(DATA_WIDTH), .OUT_WIDTH(MID_WIDTH),
        .FRAC_BITS(FRAC_BITS), .SUB_MASK(4'b0000)
    ) u_td (
        .clk(clk),
        .a('{request.quat_x, request.quat_y, request.quat_z, data_t'(0)}),
        .b('{request.vec_x,  request.vec_y,  request.vec_z,  data_t'(0)}),
        .sum(t_d), .sat(sat_td)
    );

    // second product: t * conj(q), vector part only
    qrv_mac4 #(
        .A_WIDTH(MID_WIDTH), .B_WIDTH(DATA_WIDTH), .OUT_WIDTH(DATA_WIDTH),
        .FRAC_BITS(FRAC_BITS), .SUB_MASK(4'b0100)
    ) u_rx (
        .clk(clk),
        .a('{t_d, t_x, t_y, t_z}),
        .b('{qx_d2_reg, qw_d2_reg, qz_d2_reg, qy_d2_reg}),
        .sum(r_x), .sat(sat_rx)
    );

    qrv_mac4 #(
        .A_WIDTH(MID_WIDTH), .B_WIDTH(DATA_WIDTH), .OUT_WIDTH(DATA_WIDTH),
        .FRAC_BITS(FRAC_BITS), .SUB_MASK(4'b0100)
    ) u_ry (
        .clk(clk),
        .a('{t_d, t_y, t_z, t_x}),
        .b('{qy_d2_reg, qw_d2_reg, qx_d2_reg, qz_d2_reg}),
        .sum(r_y), .sat(sat_ry)
    );

    qrv_mac4 #(
        .A_WIDTH(MID_WIDTH), .B_WIDTH(DATA_WIDTH), .OUT_WIDTH(DATA_WIDTH),
        .FRAC_BITS(FRAC_BITS), .SUB_MASK(4'b0100)
    ) u_rz (
        .clk(clk),
        .a('{t_d, t_z, t_x, t_y}),
        .b('{qz_d2_reg, qw_d2_reg, qy_d2_reg, qx_d2_reg}),
        .sum(r_z), .sat(sat_rz)
    );

    assign busy            = 1'b0;
    assign done            = vld_reg[3];
    assign result.rot_x    = r_x;
    assign result.rot_y    = r_y;
    assign result.rot_z    = r_z;
    assign result.overflow = sat_rx | sat_ry | sat_rz | ovf1_d2_reg;

endmodule
